FILE: hdl/dual_reel_machine_controller_macros.svh
// Assertion macros for the dual reel machine controller checker.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef DUAL_REEL_MACHINE_CONTROLLER_MACROS_SVH
`define DUAL_REEL_MACHINE_CONTROLLER_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define DRMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also runs during reset.
`define DRMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hdl/drmc_pkg.sv
// Shared constants for the dual reel machine controller.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package drmc_pkg;

    // counter width default and reset load of both period registers
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int RESET_PERIOD    = 100;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_BLINK_PERIOD = 2'd0,
        REG_PULSE_LENGTH = 2'd1
    } cfg_reg_t;

    // stream payloads
    localparam int S_TDATA_WIDTH = 8;
    localparam int OUT_FIELDS    = 9;
    localparam int M_TDATA_WIDTH = 16;

    // bit positions inside m_tdata
    localparam int OUT_DRIVE_ON    = 0;
    localparam int OUT_OPEN_A      = 1;
    localparam int OUT_CLOSE_A     = 2;

endpackage

`default_nettype wire

FILE: hdl/dual_reel_machine_controller.sv
// Dual reel machine controller: drive, leaves, lamp and tension control per scan tick.
// Depends on drmc_pkg for widths, register indexes and reset constants.
//
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    one scan tick, 8 sensor and button bits
// m_       out  m_tvalid/m_tready    one result per tick, 9 output lines
// cfg_     in   cfg_wr_en            blink_period, pulse_length
//
// One tick per clock unless m_ stalls: the beat is worked on between the state
// registers and the output register and is ready on m_ the cycle after it is accepted.
// Reset (aresetn low, synchronous) empties the output register and loads the
// state and both registers with their power-up values.
// A stall on m_ holds the result; s_tready stays high while the output
// register is empty or being drained in the same cycle.
`default_nettype none

module dual_reel_machine_controller
    import drmc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,

    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // selected_a, selected_b, open_button_a, close_button_a, tension_button_a,
    // open_button_b, close_button_b, tension_button_b
    input  wire logic [S_TDATA_WIDTH-1:0]   s_tdata,

    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // drive_on, open_out_a, close_out_a, leaves_lamp_a, run_lamp_a,
    // open_out_b, close_out_b, leaves_lamp_b, run_lamp_b, 7 zero bits
    output logic [M_TDATA_WIDTH-1:0]        m_tdata
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE   = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] CNT_RESET = COUNT_WIDTH'(RESET_PERIOD);

    // take the low COUNT_WIDTH bits of a register, zero-extended if wider
    function automatic logic [COUNT_WIDTH-1:0] fit_count(input logic [CFG_DATA_WIDTH-1:0] v);
        logic [COUNT_WIDTH-1:0] f;
        for (int i = 0; i < COUNT_WIDTH; i++) begin
            if (i < CFG_DATA_WIDTH) begin
                f[i] = v[i];
            end else begin
                f[i] = 1'b0;
            end
        end
        return f;
    endfunction

    logic [CFG_DATA_WIDTH-1:0] blink_period_reg;
    logic [CFG_DATA_WIDTH-1:0] pulse_length_reg;

    logic                   drive_reg,    drive_next;
    logic                   opened_reg    [2];
    logic                   opened_next   [2];
    logic                   blinking_reg  [2];
    logic                   blinking_next [2];
    logic                   lit_reg       [2];
    logic                   lit_next      [2];
    logic [COUNT_WIDTH-1:0] blink_cnt_reg [2];
    logic [COUNT_WIDTH-1:0] blink_cnt_next[2];
    logic [COUNT_WIDTH-1:0] pulse_cnt_reg [2];
    logic [COUNT_WIDTH-1:0] pulse_cnt_next[2];
    logic                   open_act_reg  [2];
    logic                   open_act_next [2];
    logic                   close_act_reg [2];
    logic                   close_act_next[2];
    logic                   tension_reg   [2];
    logic                   tension_next  [2];
    logic                   tbtn_last_reg [2];
    logic                   tbtn_last_next[2];

    logic                      m_tvalid_reg;
    logic [M_TDATA_WIDTH-1:0]  m_tdata_reg;
    logic [M_TDATA_WIDTH-1:0]  m_tdata_next;

    logic                   accept;
    logic                   sel_any;
    logic                   drop_all;
    logic                   tension_mid[2];
    logic                   sel_tension;
    logic                   sel_opened;
    logic                   stopped;
    logic                   open_btn;
    logic                   close_btn;
    logic                   tens_btn;
    logic [COUNT_WIDTH-1:0] blink_load;
    logic [COUNT_WIDTH-1:0] pulse_load;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        blink_load = fit_count(blink_period_reg);
        pulse_load = fit_count(pulse_length_reg);

        // drive: stop and drop tension with no reel selected, A wins a tie
        sel_any  = s_tdata[0] || s_tdata[1];
        drop_all = !sel_any && drive_reg;
        for (int r = 0; r < 2; r++) begin
            tension_mid[r] = tension_reg[r] && !drop_all;
        end
        sel_tension = s_tdata[0] ? tension_mid[0] : tension_mid[1];
        sel_opened  = s_tdata[0] ? opened_reg[0]  : opened_reg[1];
        drive_next  = drive_reg && !drop_all;
        if (sel_any && !drive_next && (!sel_tension || !sel_opened)) begin
            drive_next = 1'b1;
        end

        stopped   = 1'b0;
        open_btn  = 1'b0;
        close_btn = 1'b0;
        tens_btn  = 1'b0;
        for (int r = 0; r < 2; r++) begin
            open_btn  = s_tdata[2 + 3*r];
            close_btn = s_tdata[3 + 3*r];
            tens_btn  = s_tdata[4 + 3*r];
            stopped   = !drive_next || !tension_mid[r];

            opened_next[r]    = opened_reg[r];
            blinking_next[r]  = blinking_reg[r];
            lit_next[r]       = lit_reg[r];
            blink_cnt_next[r] = blink_cnt_reg[r];
            pulse_cnt_next[r] = pulse_cnt_reg[r];
            open_act_next[r]  = open_act_reg[r];
            close_act_next[r] = close_act_reg[r];

            // leaves buttons, open wins while closed
            if (open_btn && !opened_reg[r] && stopped) begin
                opened_next[r]    = 1'b1;
                blinking_next[r]  = 1'b1;
                blink_cnt_next[r] = blink_load;
                lit_next[r]       = 1'b1;
                pulse_cnt_next[r] = pulse_load;
                close_act_next[r] = 1'b0;
                open_act_next[r]  = 1'b1;
            end else if (close_btn && opened_reg[r] && stopped) begin
                opened_next[r]    = 1'b0;
                blinking_next[r]  = 1'b0;
                lit_next[r]       = 1'b1;
                pulse_cnt_next[r] = pulse_load;
                open_act_next[r]  = 1'b0;
                close_act_next[r] = 1'b1;
            end

            // blink counter: reload at zero, toggle lamp if blinking
            if (blink_cnt_next[r] != '0) begin
                blink_cnt_next[r] = blink_cnt_next[r] - CNT_ONE;
            end else begin
                blink_cnt_next[r] = blink_load;
                if (blinking_next[r]) begin
                    lit_next[r] = !lit_next[r];
                end
            end

            // actuator pulse: drop both lines at zero
            if (pulse_cnt_next[r] != '0) begin
                pulse_cnt_next[r] = pulse_cnt_next[r] - CNT_ONE;
            end else begin
                open_act_next[r]  = 1'b0;
                close_act_next[r] = 1'b0;
            end

            // tension toggles on button release
            tension_next[r]   = tension_mid[r] ^ (tbtn_last_reg[r] && !tens_btn);
            tbtn_last_next[r] = tens_btn;
        end

        m_tdata_next = M_TDATA_WIDTH'({tension_next[1], lit_next[1], close_act_next[1],
                                       open_act_next[1], tension_next[0], lit_next[0],
                                       close_act_next[0], open_act_next[0], drive_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_period_reg <= CFG_DATA_WIDTH'(RESET_PERIOD);
            pulse_length_reg <= CFG_DATA_WIDTH'(RESET_PERIOD);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BLINK_PERIOD: blink_period_reg <= cfg_wdata;
                REG_PULSE_LENGTH: pulse_length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= 1'b0;
            for (int r = 0; r < 2; r++) begin
                opened_reg[r]    <= 1'b0;
                blinking_reg[r]  <= 1'b0;
                lit_reg[r]       <= 1'b1;
                blink_cnt_reg[r] <= '0;
                pulse_cnt_reg[r] <= CNT_RESET;
                open_act_reg[r]  <= 1'b0;
                close_act_reg[r] <= 1'b1;
                tension_reg[r]   <= 1'b0;
                tbtn_last_reg[r] <= 1'b0;
            end
        end else if (accept) begin
            drive_reg <= drive_next;
            for (int r = 0; r < 2; r++) begin
                opened_reg[r]    <= opened_next[r];
                blinking_reg[r]  <= blinking_next[r];
                lit_reg[r]       <= lit_next[r];
                blink_cnt_reg[r] <= blink_cnt_next[r];
                pulse_cnt_reg[r] <= pulse_cnt_next[r];
                open_act_reg[r]  <= open_act_next[r];
                close_act_reg[r] <= close_act_next[r];
                tension_reg[r]   <= tension_next[r];
                tbtn_last_reg[r] <= tbtn_last_next[r];
            end
        end
    end

    // output register: load on every accepted beat, empty when drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/drmc_checker.sv
// Port-level checker for the dual reel machine controller, bound to the top level.
// Depends on drmc_pkg and dual_reel_machine_controller_macros.svh.
`default_nettype none

`include "dual_reel_machine_controller_macros.svh"

module drmc_checker
    import drmc_pkg::*;
(
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic [S_TDATA_WIDTH-1:0]   s_tdata,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [M_TDATA_WIDTH-1:0]   m_tdata
);

    // a stalled result beat holds its payload
    `DRMC_ASSERT(a_out_hold,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
        "result beat changed while stalled")

    // reset leaves no result pending
    `DRMC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid,
        "result valid right after reset")

    // an empty output register never blocks the input
    `DRMC_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready,
        "input stalled with empty output register")

    // open and close actuators of reel A never drive together
    `DRMC_ASSERT(a_open_close_excl,
        m_tvalid |-> !(m_tdata[OUT_OPEN_A] && m_tdata[OUT_CLOSE_A]),
        "reel A open and close both active")

    // a tick with no reel selected leaves the drive off
    `DRMC_ASSERT(a_no_sel_stops,
        (s_tvalid && s_tready && !s_tdata[0] && !s_tdata[1])
            |=> (m_tvalid && !m_tdata[OUT_DRIVE_ON]),
        "drive on with no reel selected")

endmodule

bind dual_reel_machine_controller drmc_checker u_drmc_checker (.*);

`default_nettype wire

FILE: tb/tb_dual_reel_machine_controller.sv
// Self-checking bench for the dual reel machine controller: random scan ticks
// on s_, results checked on m_ against an in-bench model of drive, leaves and tension.
// Depends on drmc_pkg and dual_reel_machine_controller.
`timescale 1ns / 1ps
`default_nettype none

module tb_dual_reel_machine_controller;
    import drmc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_INDEX = 2'd3;

    typedef struct packed {
        logic tension_button_b;
        logic close_button_b;
        logic open_button_b;
        logic tension_button_a;
        logic close_button_a;
        logic open_button_a;
        logic selected_b;
        logic selected_a;
    } scan_tick_t;

    typedef struct packed {
        logic run_lamp_b;
        logic leaves_lamp_b;
        logic close_out_b;
        logic open_out_b;
        logic run_lamp_a;
        logic leaves_lamp_a;
        logic close_out_a;
        logic open_out_a;
        logic drive_on;
    } reel_lines_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [S_TDATA_WIDTH-1:0]   s_tdata   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [M_TDATA_WIDTH-1:0]   m_tdata;

    dual_reel_machine_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // controller model state, loaded with its power-up values
    logic [COUNT_WIDTH_DEF-1:0] blink_reload = COUNT_WIDTH_DEF'(RESET_PERIOD);
    logic [COUNT_WIDTH_DEF-1:0] pulse_reload = COUNT_WIDTH_DEF'(RESET_PERIOD);
    logic                       drive_running = 1'b0;
    logic                       leaves_open [2] = '{1'b0, 1'b0};
    logic                       blinking    [2] = '{1'b0, 1'b0};
    logic                       lamp_lit    [2] = '{1'b1, 1'b1};
    logic [COUNT_WIDTH_DEF-1:0] blink_cnt   [2] = '{'0, '0};
    logic [COUNT_WIDTH_DEF-1:0] pulse_cnt   [2] = '{COUNT_WIDTH_DEF'(RESET_PERIOD),
                                                   COUNT_WIDTH_DEF'(RESET_PERIOD)};
    logic                       open_act    [2] = '{1'b0, 1'b0};
    logic                       close_act   [2] = '{1'b1, 1'b1};
    logic                       tension_on  [2] = '{1'b0, 1'b0};
    logic                       tension_prev[2] = '{1'b0, 1'b0};

    logic [S_TDATA_WIDTH-1:0] pending_scans [$];
    reel_lines_t              lines_due [$];
    logic [S_TDATA_WIDTH-1:0] scan_prev = '0;

    int          errors = 0;
    int          results = 0;
    int          writes = 0;
    int          openings = 0;
    int          toggles = 0;
    int          starts = 0;
    int          cycles = 0;
    int unsigned s_wait = 0;
    int unsigned m_wait = 0;
    bit          s_calm = 1'b0;
    bit          m_calm = 1'b0;

    string line_name [0:8] = '{"drive_on", "open_out_a", "close_out_a", "leaves_lamp_a",
                               "run_lamp_a", "open_out_b", "close_out_b", "leaves_lamp_b",
                               "run_lamp_b"};

    function automatic void reel_step(int r, logic open_btn, logic close_btn, logic tens_btn);
        logic stopped;
        stopped = !drive_running || !tension_on[r];
        if (open_btn && !leaves_open[r] && stopped) begin
            leaves_open[r] = 1'b1;
            blinking[r]    = 1'b1;
            blink_cnt[r]   = blink_reload;
            lamp_lit[r]    = 1'b1;
            pulse_cnt[r]   = pulse_reload;
            close_act[r]   = 1'b0;
            open_act[r]    = 1'b1;
            openings++;
        end else if (close_btn && leaves_open[r] && stopped) begin
            leaves_open[r] = 1'b0;
            blinking[r]    = 1'b0;
            lamp_lit[r]    = 1'b1;
            pulse_cnt[r]   = pulse_reload;
            open_act[r]    = 1'b0;
            close_act[r]   = 1'b1;
        end
        if (blink_cnt[r] != 0) begin
            blink_cnt[r] = blink_cnt[r] - 1'b1;
        end else begin
            blink_cnt[r] = blink_reload;
            if (blinking[r])
                lamp_lit[r] = !lamp_lit[r];
        end
        if (pulse_cnt[r] != 0) begin
            pulse_cnt[r] = pulse_cnt[r] - 1'b1;
        end else begin
            open_act[r]  = 1'b0;
            close_act[r] = 1'b0;
        end
        // tension flips on the falling edge of its button
        if (tension_prev[r] != tens_btn) begin
            if (!tens_btn) begin
                tension_on[r] = !tension_on[r];
                toggles++;
            end
            tension_prev[r] = tens_btn;
        end
    endfunction

    function automatic reel_lines_t scan_lines(scan_tick_t t);
        reel_lines_t o;
        int          sel;
        if (!t.selected_a && !t.selected_b && drive_running) begin
            drive_running = 1'b0;
            tension_on[0] = 1'b0;
            tension_on[1] = 1'b0;
        end
        if (t.selected_a || t.selected_b) begin
            sel = t.selected_a ? 0 : 1;
            if (!drive_running && (!tension_on[sel] || !leaves_open[sel])) begin
                drive_running = 1'b1;
                starts++;
            end
        end
        reel_step(0, t.open_button_a, t.close_button_a, t.tension_button_a);
        reel_step(1, t.open_button_b, t.close_button_b, t.tension_button_b);
        o.drive_on      = drive_running;
        o.open_out_a    = open_act[0];
        o.close_out_a   = close_act[0];
        o.leaves_lamp_a = lamp_lit[0];
        o.run_lamp_a    = tension_on[0];
        o.open_out_b    = open_act[1];
        o.close_out_b   = close_act[1];
        o.leaves_lamp_b = lamp_lit[1];
        o.run_lamp_b    = tension_on[1];
        return o;
    endfunction

    // beat driver: present queued ticks, random gap after each accepted beat
    always @(posedge aclk) begin
        int unsigned gap;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_wait   <= 0;
        end else begin
            gap = s_wait;
            if (s_tvalid && s_tready) begin
                lines_due.push_back(scan_lines(scan_tick_t'(s_tdata)));
                if ($urandom_range(0, 39) == 0)
                    s_calm = !s_calm;
                gap = s_calm ? 0 : $urandom_range(0, 15);
            end
            if (!s_tvalid || s_tready) begin
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    s_wait   <= gap - 1;
                end else if (pending_scans.size() != 0) begin
                    s_tdata  <= pending_scans.pop_front();
                    s_tvalid <= 1'b1;
                    s_wait   <= 0;
                end else begin
                    s_tvalid <= 1'b0;
                    s_wait   <= 0;
                end
            end
        end
    end

    // result monitor: check each beat against the oldest expectation, random stalls
    always @(posedge aclk) begin
        reel_lines_t got;
        reel_lines_t want;
        int unsigned stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_wait   <= 0;
        end else begin
            stall = m_wait;
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_FIELDS-1:0];
                if (lines_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %b", $time, got);
                    errors++;
                end else begin
                    want = lines_due.pop_front();
                    for (int f = 0; f < OUT_FIELDS; f++) begin
                        if (got[f] !== want[f]) begin
                            $display("%0t: %s expected %b, actual %b", $time, line_name[f],
                                     want[f], got[f]);
                            errors++;
                        end
                    end
                end
                results++;
                if ($urandom_range(0, 39) == 0)
                    m_calm = !m_calm;
                stall = m_calm ? 0 : $urandom_range(0, 15);
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                m_wait   <= stall - 1;
            end else begin
                m_tready <= 1'b1;
                m_wait   <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, lines_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic set_register(logic [CFG_INDEX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_BLINK_PERIOD: blink_reload = value;
            REG_PULSE_LENGTH: pulse_reload = value;
            default: ;
        endcase
        writes++;
    endtask

    // queue n ticks, then drain so the block is idle before the next register write
    task automatic feed_scans(int n);
        logic [S_TDATA_WIDTH-1:0] t;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 6) == 0) begin
                t = S_TDATA_WIDTH'($urandom_range(0, 255));
            end else begin
                // mostly held levels: sensors change rarely, buttons get pressed and released
                t = scan_prev;
                for (int b = 0; b < S_TDATA_WIDTH; b++)
                    if ($urandom_range(0, (b < 2) ? 15 : 5) == 0)
                        t[b] = ~t[b];
            end
            pending_scans.push_back(t);
            scan_prev = t;
        end
        while (pending_scans.size() != 0 || s_tvalid || lines_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        // bit order, high to low: tb cb ob ta ca oa sb sa
        pending_scans = '{
            8'b0000_0000,  // nothing selected
            8'b1111_1111,  // all pressed: open beats close on closed leaves
            8'b0000_0011,  // both selected, tension released on both
            8'b0100_1101,  // close while running with tension: no effect
            8'b0000_0000,  // deselect while running: stop, drop tension
            8'b0100_1000,  // close both while stopped
            8'b0000_0010,  // reel B alone starts the drive
            8'b1001_0010,
            8'b0000_0010,  // tension on for both
            8'b0010_0110,  // open while running with tension: no effect
            8'b0000_0000,
            8'b0010_0100,  // open both while stopped
            8'b0000_0001,
            8'b0000_0000,
            8'b0001_0000,
            8'b0000_0000,  // tension A on with drive off
            8'b0000_0001,  // tension on and leaves open: drive stays off
            8'b0000_0011,
            8'b0000_1001,  // close A while the drive is off
            8'b0000_0001,  // now the drive starts
            8'b0000_0010
        };
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        feed_scans(150);

        set_register(REG_BLINK_PERIOD, '0);
        set_register(REG_PULSE_LENGTH, '0);
        feed_scans(200);

        set_register(REG_BLINK_PERIOD, '1);
        set_register(REG_PULSE_LENGTH, '1);
        feed_scans(150);

        set_register(REG_BLINK_PERIOD, 16'd1);
        set_register(REG_PULSE_LENGTH, 16'd2);
        feed_scans(250);

        set_register(REG_BLINK_PERIOD, CFG_DATA_WIDTH'($urandom_range(0, 20)));
        set_register(REG_PULSE_LENGTH, CFG_DATA_WIDTH'($urandom_range(0, 20)));
        feed_scans(250);

        // a write to an index past the register list must change nothing
        set_register(REG_SPARE_INDEX, CFG_DATA_WIDTH'($urandom_range(0, 65535)));
        set_register(REG_BLINK_PERIOD, CFG_DATA_WIDTH'($urandom_range(0, 65535)));
        set_register(REG_PULSE_LENGTH, CFG_DATA_WIDTH'($urandom_range(0, 65535)));
        feed_scans(150);

        set_register(REG_BLINK_PERIOD, CFG_DATA_WIDTH'($urandom_range(0, 8)));
        set_register(REG_PULSE_LENGTH, CFG_DATA_WIDTH'($urandom_range(0, 8)));
        feed_scans(250);

        $display("Checked %0d result beats across %0d register writes (periods 0 to 65535).",
                 results, writes);
        $display("Drive started %0d times, leaves opened %0d times, tension toggled %0d times.",
                 starts, openings, toggles);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
